// ===== rtl/ssh_pkg.sv =====
// Package with the shared constants, mode codes and command type of the string hash unit.
`timescale 1ns / 1ps
`default_nettype none

package ssh_pkg;

    // Word and field widths.
    localparam int HASH_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int MODE_W       = 3;
    localparam int MAX_WORD_LEN = 255;
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int DIV_CNT_W    = $clog2(HASH_W);

    // Hash mode codes.
    localparam logic [MODE_W-1:0] MODE_ZERO   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUM    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LENGTH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_AVG    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROTXOR = 3'd5;
    localparam logic [MODE_W-1:0] MODE_X33    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_X31    = 3'd7;

    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_X33;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              take;        // an input beat is accepted
        logic              finish;      // the accepted beat ends the word
        logic              load_direct; // write the finished hash to the output register
        logic              start_div;   // load the divider with sum and length
        logic              div_step;    // run one quotient bit
        logic              load_div;    // write the signed quotient to the output register
        logic [MODE_W-1:0] mode;        // hash mode in effect
    } ssh_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ssh_ctrl.sv =====
// Controller of the string hash unit: handshakes, mode register and divide sequencing.
`timescale 1ns / 1ps
`default_nettype none

module ssh_ctrl
    import ssh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MODE_W-1:0] cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_last_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ssh_cmd_t               cmd
);

    localparam logic ST_ACC = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic                 state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;
    logic                 in_fire;
    logic                 div_last;

    // The output register can take a result when empty or drained this cycle.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_ACC) && (!s_last_byte || out_free);
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign div_last  = (state_reg == ST_DIV) && (cnt_reg == DIV_CNT_W'(HASH_W - 1));

    // Command decode.
    always_comb begin
        cmd.take        = in_fire;
        cmd.finish      = in_fire && s_last_byte;
        cmd.start_div   = in_fire && s_last_byte && (mode_reg == MODE_AVG);
        cmd.load_direct = in_fire && s_last_byte && (mode_reg != MODE_AVG);
        cmd.div_step    = (state_reg == ST_DIV);
        cmd.load_div    = div_last;
        cmd.mode        = mode_reg;
    end

    // Next state.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mode_next    = mode_reg;
        m_valid_next = m_valid_reg;
        if (cfg_valid) begin
            mode_next = cfg_data;
        end
        case (state_reg)
            ST_ACC: begin
                if (cmd.start_div) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last) begin
                    state_next = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
        if (cmd.load_direct || cmd.load_div) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            cnt_reg     <= '0;
            mode_reg    <= MODE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ssh_datapath.sv =====
// Datapath of the string hash unit: accumulator, length, first byte, divider and output register.
`timescale 1ns / 1ps
`default_nettype none

module ssh_datapath
    import ssh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ssh_cmd_t          cmd,
    input  wire logic [BYTE_W-1:0] s_byte_in,
    output logic [HASH_W-1:0]      hash_out
);

    logic [HASH_W-1:0] acc_reg, acc_next, acc_fold;
    logic [LEN_W-1:0]  len_reg, len_next, len_inc;
    logic [BYTE_W-1:0] first_reg, first_next, first_cur;
    logic [HASH_W-1:0] byte_ext;
    logic [HASH_W-1:0] finish_val;

    logic [HASH_W-1:0] quo_reg, quo_next, quo_step;
    logic [LEN_W-1:0]  rem_reg, rem_next, rem_step;
    logic [LEN_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic [LEN_W:0]    trial;
    logic              qbit;

    logic [HASH_W-1:0] hash_reg, hash_next;

    assign byte_ext = {{(HASH_W - BYTE_W){1'b0}}, s_byte_in};

    // Fold one byte into the accumulator with the current mode.
    always_comb begin
        case (cmd.mode)
            MODE_ROTXOR: acc_fold = {acc_reg[0], acc_reg[HASH_W-1:1]} ^ byte_ext;
            MODE_X33:    acc_fold = (acc_reg << 5) + acc_reg + byte_ext;
            MODE_X31:    acc_fold = (acc_reg << 5) - acc_reg + byte_ext;
            default:     acc_fold = acc_reg + byte_ext;
        endcase
    end

    // Saturating length and first byte of the word.
    assign len_inc   = (len_reg < LEN_W'(MAX_WORD_LEN)) ? len_reg + 1'b1 : len_reg;
    assign first_cur = (len_reg == '0) ? s_byte_in : first_reg;

    // Hash of the finished word for every mode but the average.
    always_comb begin
        case (cmd.mode)
            MODE_ZERO:   finish_val = '0;
            MODE_FIRST:  finish_val = {{(HASH_W - BYTE_W){1'b0}}, first_cur};
            MODE_LENGTH: finish_val = {{(HASH_W - LEN_W){1'b0}}, len_inc};
            default:     finish_val = acc_fold;
        endcase
    end

    // Word state update; the word state clears after its last beat.
    always_comb begin
        acc_next   = acc_reg;
        len_next   = len_reg;
        first_next = first_reg;
        if (cmd.finish) begin
            acc_next   = '0;
            len_next   = '0;
            first_next = '0;
        end else if (cmd.take) begin
            acc_next   = acc_fold;
            len_next   = len_inc;
            first_next = first_cur;
        end
    end

    // One restoring divide step on the magnitude of the sum.
    assign trial    = {rem_reg, quo_reg[HASH_W-1]};
    assign qbit     = (trial >= {1'b0, dvs_reg});
    assign rem_step = qbit ? LEN_W'(trial - {1'b0, dvs_reg}) : trial[LEN_W-1:0];
    assign quo_step = {quo_reg[HASH_W-2:0], qbit};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.start_div) begin
            quo_next = acc_fold[HASH_W-1] ? (~acc_fold + 1'b1) : acc_fold;
            rem_next = '0;
        end else if (cmd.div_step) begin
            quo_next = quo_step;
            rem_next = rem_step;
        end
    end

    // Output register.
    always_comb begin
        hash_next = hash_reg;
        if (cmd.load_direct) begin
            hash_next = finish_val;
        end else if (cmd.load_div) begin
            hash_next = neg_reg ? (~quo_step + 1'b1) : quo_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            len_reg   <= '0;
            first_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        hash_reg <= hash_next;
        if (cmd.start_div) begin
            dvs_reg <= len_inc;
            neg_reg <= acc_fold[HASH_W-1];
        end
    end

    assign hash_out = hash_reg;

endmodule

`default_nettype wire

// ===== rtl/selectable_string_hash_unit.sv =====
// Top level of the selectable string hash unit.
// Bytes are taken one per cycle while s_ready is high; outside sum/length mode a result
// appears in the cycle after the last byte of a word. In sum/length mode a bit-serial divider
// gives one quotient bit per cycle, and no input beat is taken until the last bit is loaded.
// Outside a divide, the last byte waits only while an earlier result is held and not taken.
// Synchronous active-low reset clears the word state and sets the hash mode to times 33.
`timescale 1ns / 1ps
`default_nettype none

module selectable_string_hash_unit
    import ssh_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [MODE_W-1:0] cfg_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_byte_in,
    input  wire logic              s_last_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [HASH_W-1:0] m_hash_value
);

    ssh_cmd_t          cmd;
    logic [HASH_W-1:0] hash_out;

    ssh_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd)
    );

    ssh_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_byte_in (s_byte_in),
        .hash_out  (hash_out)
    );

    assign m_hash_value = hash_out;

endmodule

`default_nettype wire

// ===== dv/selectable_string_hash_unit_test.sv =====
// Self-checking testbench for the selectable string hash unit.
`timescale 1ns / 1ps

module selectable_string_hash_unit_test;
    import ssh_pkg::*;

    // Run control.
    localparam int CHAR_TARGET    = 1550;
    localparam int DRAIN_CYCLES   = 40;    // covers the divide plus margin
    localparam int BACKLOG_CYCLES = 400;
    localparam int STALL_LIMIT    = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam int FACTOR_X33     = 33;
    localparam int FACTOR_X31     = 31;

    // Receiver stall styles.
    typedef enum int {
        SINK_OPEN,
        SINK_MOSTLY_READY,
        SINK_MOSTLY_STALLED,
        SINK_PERIODIC
    } sink_style_t;

    // One row of the directed table.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] char_code;
        logic              last;
        logic              pinned;
        logic [HASH_W-1:0] hash;
    } probe_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [MODE_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [BYTE_W-1:0] s_byte_in;
    logic s_last_byte;
    logic m_valid;
    logic m_ready;
    logic signed [HASH_W-1:0] m_hash_value;

    // Typed-in expectation that travels with the input beat.
    logic              s_pin;
    logic [HASH_W-1:0] s_pin_hash;

    // Predictor state.
    logic [MODE_W-1:0] mode_now;
    logic [HASH_W-1:0] word_acc;
    logic [LEN_W-1:0]  word_len;
    logic [BYTE_W-1:0] word_first;
    logic [HASH_W-1:0] hashes_due[$];

    // Stimulus bookkeeping.
    logic [MODE_W-1:0] mode_set;
    int chars_sent;
    int fault_count;
    int burst_left;
    int gap_max;
    logic backlog_armed;
    logic backlog_done;

    // Directed table: extremes, every mode, zero bytes, and a mode change inside a word.
    probe_row_t probe_rows [0:20] = '{
        '{MODE_X33,    8'h61, 1'b1, 1'b1, 32'h0000_0061},
        '{MODE_ZERO,   8'hFF, 1'b1, 1'b1, 32'h0000_0000},
        '{MODE_FIRST,  8'h00, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_FIRST,  8'hFF, 1'b1, 1'b1, 32'h0000_0000},
        '{MODE_FIRST,  8'hFF, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_FIRST,  8'h01, 1'b1, 1'b1, 32'h0000_00FF},
        '{MODE_SUM,    8'hFF, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_SUM,    8'hFF, 1'b1, 1'b1, 32'h0000_01FE},
        '{MODE_LENGTH, 8'h00, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_LENGTH, 8'h00, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_LENGTH, 8'h00, 1'b1, 1'b1, 32'h0000_0003},
        '{MODE_AVG,    8'hFF, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_AVG,    8'h01, 1'b1, 1'b1, 32'h0000_0080},
        '{MODE_ROTXOR, 8'h01, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_ROTXOR, 8'h00, 1'b1, 1'b1, 32'h8000_0000},
        '{MODE_X31,    8'hFF, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_X31,    8'h01, 1'b1, 1'b0, 32'h0000_0000},
        '{MODE_X33,    8'h80, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_X31,    8'hFF, 1'b0, 1'b0, 32'h0000_0000},
        '{MODE_SUM,    8'h01, 1'b1, 1'b0, 32'h0000_0000},
        '{MODE_AVG,    8'hFF, 1'b1, 1'b1, 32'h0000_00FF}
    };

    selectable_string_hash_unit i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    // 100 MHz clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Fold one accepted character into the predicted word state and queue the hash on the last one.
    task automatic absorb_char(input logic [BYTE_W-1:0] char_code, input logic last,
                               input logic pinned, input logic [HASH_W-1:0] pin_hash);
        logic [HASH_W-1:0] hash;
        int quotient;
        if (word_len == 0) begin
            word_first = char_code;
        end
        case (mode_now)
            MODE_ROTXOR: word_acc = {word_acc[0], word_acc[HASH_W-1:1]} ^ HASH_W'(char_code);
            MODE_X33:    word_acc = word_acc * FACTOR_X33 + char_code;
            MODE_X31:    word_acc = word_acc * FACTOR_X31 + char_code;
            default:     word_acc = word_acc + char_code;
        endcase
        if (word_len < MAX_WORD_LEN) begin
            word_len = word_len + 1'b1;
        end
        if (last) begin
            case (mode_now)
                MODE_ZERO:   hash = '0;
                MODE_FIRST:  hash = HASH_W'(word_first);
                MODE_LENGTH: hash = HASH_W'(word_len);
                MODE_AVG: begin
                    // Signed sum, truncating divide by the (saturated) length.
                    quotient = signed'(word_acc) / int'(word_len);
                    hash = quotient;
                end
                default:     hash = word_acc;
            endcase
            hashes_due.push_back(pinned ? pin_hash : hash);
            word_acc = '0;
            word_len = '0;
            word_first = '0;
        end
    endtask

    // Sample every channel at the rising edge; results are checked before new beats are queued.
    always @(posedge aclk) begin : scoreboard
        logic [HASH_W-1:0] want;
        if (!aresetn) begin
            mode_now = MODE_RESET;
            word_acc = '0;
            word_len = '0;
            word_first = '0;
            hashes_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (hashes_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("unexpected result beat: hash_value %h", m_hash_value);
                    end
                end else begin
                    want = hashes_due.pop_front();
                    if (m_hash_value !== want) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS) begin
                            $display("hash_value mismatch: expected %h, actual %h",
                                     want, m_hash_value);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                mode_now = cfg_data;
            end
            if (s_valid && s_ready) begin
                absorb_char(s_byte_in, s_last_byte, s_pin, s_pin_hash);
            end
        end
    end

    // Offer one character; the sender idles between bursts when gaps are enabled.
    task automatic send_char(input logic [BYTE_W-1:0] char_code, input logic last,
                             input logic pinned, input logic [HASH_W-1:0] pin_hash);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            repeat (gap) begin
                @(negedge aclk);
                s_valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid = 1'b1;
        s_byte_in = char_code;
        s_last_byte = last;
        s_pin = pinned;
        s_pin_hash = pin_hash;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        chars_sent++;
    endtask

    // Write the hash mode once the unit has drained every pending result.
    task automatic set_mode(input logic [MODE_W-1:0] mode);
        @(negedge aclk);
        s_valid = 1'b0;
        while (hashes_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = mode;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        mode_set = mode;
    endtask

    // Send one complete word of random bytes; a few words run past the length saturation.
    task automatic send_word(input int forced_len);
        int len;
        int pick;
        pick = $urandom_range(0, 99);
        if (forced_len != 0) begin
            len = forced_len;
        end else if (pick == 0) begin
            len = $urandom_range(MAX_WORD_LEN + 1, MAX_WORD_LEN + 15);
        end else if (pick < 20) begin
            len = $urandom_range(13, 60);
        end else begin
            len = $urandom_range(1, 12);
        end
        for (int k = 0; k < len; k++) begin
            send_char(BYTE_W'($urandom_range(0, 255)), k == len - 1, 1'b0, '0);
        end
    endtask

    // Main stimulus: reset, directed table, then random phases with mode changes between them.
    initial begin : stimulus
        int words;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_byte_in = '0;
        s_last_byte = 1'b0;
        s_pin = 1'b0;
        s_pin_hash = '0;
        mode_set = MODE_RESET;
        chars_sent = 0;
        fault_count = 0;
        burst_left = 0;
        gap_max = 3;
        backlog_armed = 1'b0;
        backlog_done = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows; a mode change between rows of one word lands mid-word.
        for (int i = 0; i < $size(probe_rows); i++) begin
            if (probe_rows[i].mode != mode_set) begin
                set_mode(probe_rows[i].mode);
            end
            send_char(probe_rows[i].char_code, probe_rows[i].last,
                      probe_rows[i].pinned, probe_rows[i].hash);
        end

        // First random phase runs back to back in length mode while the receiver holds off.
        set_mode(MODE_LENGTH);
        gap_max = 0;
        backlog_armed = 1'b1;
        for (int w = 0; w < 60; w++) begin
            send_word((w == 10) ? MAX_WORD_LEN + 7 : 0);
        end

        // Random phases; some end inside a word so the next mode picks it up.
        while (chars_sent < CHAR_TARGET) begin
            set_mode(MODE_W'($urandom_range(0, 7)));
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            words = $urandom_range(3, 16);
            repeat (words) send_word(0);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 5)) begin
                    send_char(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
                end
            end
        end

        // Drain and let any divide still in flight finish.
        @(negedge aclk);
        s_valid = 1'b0;
        while (hashes_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("selectable_string_hash_unit regression: pass");
        end else begin
            $display("selectable_string_hash_unit regression: fail");
        end
        $finish;
    end

    // Result receiver: changing stall styles, plus one long hold-off to back the unit up.
    initial begin : result_sink
        sink_style_t style;
        int span;
        int period;
        m_ready = 1'b0;
        forever begin
            if (backlog_armed && !backlog_done) begin
                repeat ($urandom_range(10, 60)) begin
                    @(negedge aclk);
                    m_ready = 1'b1;
                end
                repeat (BACKLOG_CYCLES) begin
                    @(negedge aclk);
                    m_ready = 1'b0;
                end
                backlog_done = 1'b1;
            end else begin
                style = sink_style_t'($urandom_range(0, 3));
                span = $urandom_range(30, 200);
                period = $urandom_range(2, 5);
                for (int k = 0; k < span; k++) begin
                    @(negedge aclk);
                    case (style)
                        SINK_OPEN:           m_ready = 1'b1;
                        SINK_MOSTLY_READY:   m_ready = ($urandom_range(0, 3) != 0);
                        SINK_MOSTLY_STALLED: m_ready = ($urandom_range(0, 3) == 0);
                        default:             m_ready = ((k % period) == 0);
                    endcase
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("selectable_string_hash_unit regression: fail");
        $finish;
    end

endmodule
